/* sv/mrp_pkg.sv */
// shared types and constants for the primality tester
package mrp_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIAL,
    S_DECOMP,
    S_BASE,
    S_POW_ACC,
    S_POW_SQ,
    S_CHECK,
    S_SQR,
    S_DONE
  } state_t;

  localparam int NUM_SMALL = 12;
  localparam int NUM_BASES = 7;
  localparam logic [2:0] LAST_BASE = 3'd7;

  typedef logic [5:0] small_prime_t;
  localparam small_prime_t SMALL_PRIMES [NUM_SMALL] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
  };

  typedef struct packed {
    logic done;
    logic divisible;
  } trial_res_t;

  function automatic logic [4:0] base_of(input logic [2:0] idx);
    logic [4:0] b;
    unique case (idx)
      3'd0: b = 5'd2;
      3'd1: b = 5'd3;
      3'd2: b = 5'd5;
      3'd3: b = 5'd7;
      3'd4: b = 5'd11;
      3'd5: b = 5'd13;
      3'd6: b = 5'd17;
      default: b = 5'd0;
    endcase
    return b;
  endfunction

endpackage

/* sv/mrp_trial.sv */
// bit-serial remainders of the candidate by the twelve small primes
module mrp_trial #(
  parameter int W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [W-1:0]        n,
  output mrp_pkg::trial_res_t res
);
  import mrp_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  shreg;
  logic [CW-1:0] cnt;
  logic          run;
  logic          done;
  small_prime_t  rem [NUM_SMALL];
  logic [6:0]    t   [NUM_SMALL];
  logic          div_any;

  always_comb begin
    div_any = 1'b0;
    for (int i = 0; i < NUM_SMALL; i++) begin
      t[i] = {rem[i], shreg[W-1]};
      if (t[i] >= {1'b0, SMALL_PRIMES[i]}) t[i] = t[i] - {1'b0, SMALL_PRIMES[i]};
      if (rem[i] == 6'd0) div_any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      shreg <= n;
      for (int i = 0; i < NUM_SMALL; i++) rem[i] <= '0;
    end else if (run) begin
      shreg <= {shreg[W-2:0], 1'b0};
      for (int i = 0; i < NUM_SMALL; i++) rem[i] <= t[i][5:0];
    end
  end

  assign res.done      = done;
  assign res.divisible = div_any;

endmodule

/* sv/mrp_mulmod.sv */
// shift-and-add modular multiplier: for each multiplier bit, MSB first, a doubling step then a conditional add of x
module mrp_mulmod #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);
  import mrp_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc, xr, yr, mr;
  logic [CW-1:0] cnt;
  logic          run, phase;
  logic [W-1:0]  addend, acc_next;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] md);
    logic [W-1:0] gap;
    gap = md - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  assign addend   = phase ? xr : acc;
  assign acc_next = add_mod(acc, addend, mr);

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        phase <= 1'b0;
        cnt   <= CW'(W);
      end else if (run) begin
        phase <= ~phase;
        if (phase) begin
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= '0;
      xr  <= x;
      yr  <= y;
      mr  <= m;
    end else if (run) begin
      if (!phase) begin
        acc <= acc_next;
      end else begin
        if (yr[W-1]) acc <= acc_next;
        yr <= {yr[W-2:0], 1'b0};
      end
    end
  end

  assign prod = acc;

endmodule

/* sv/miller_rabin_primality_test_core.sv */
// top level of the deterministic miller-rabin primality tester
//
// start is taken while busy is low; done is high for one cycle with the
// verdict on probably_prime and the receiver cannot stall it. A test runs
// bit-serial trial division, then splits n-1 into d*2^s by halving, then
// for each of seven bases runs a chain of modular products in the single
// shift-and-add multiplier, about 2*WORD_BITS products per base; a
// composite that fails early finishes sooner.
module miller_rabin_primality_test_core #(
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] candidate,
  output logic        busy,
  output logic        done,
  output logic        probably_prime
);
  import mrp_pkg::*;

  localparam int W = WORD_BITS;

  state_t       state, state_next;
  logic [W-1:0] n, nm1, d, e, b, acc;
  logic [5:0]   s, r;
  logic [2:0]   bidx;
  logic         lt2, match, verdict, mul_run;
  trial_res_t   tres;
  logic         mul_go, mul_done;
  logic [W-1:0] mul_x, mul_y, mul_prod, base_w;
  logic         start_ok, in_lt2, in_match;

  assign start_ok = start && !busy;
  assign base_w   = {{(W-5){1'b0}}, base_of(bidx)};

  always_comb begin
    in_lt2   = (candidate[W-1:0] < W'(2));
    in_match = 1'b0;
    for (int i = 0; i < NUM_SMALL; i++)
      if (candidate[W-1:0] == W'(SMALL_PRIMES[i])) in_match = 1'b1;
  end

  mrp_trial #(.W(W)) u_trial (
    .clk (clk),
    .rst (rst),
    .go  (start_ok),
    .n   (candidate[W-1:0]),
    .res (tres)
  );

  mrp_mulmod #(.W(W)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .x    (mul_x),
    .y    (mul_y),
    .m    (n),
    .done (mul_done),
    .prod (mul_prod)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_TRIAL;
      S_TRIAL: begin
        if (tres.done) begin
          if (lt2 || match || tres.divisible) state_next = S_DONE;
          else state_next = S_DECOMP;
        end
      end
      S_DECOMP:  if (d[0] || s == 6'd63) state_next = S_BASE;
      S_BASE: begin
        if (bidx == LAST_BASE) state_next = S_DONE;
        else if (base_w < n) state_next = S_POW_ACC;
      end
      S_POW_ACC: if (!e[0] || mul_done) state_next = S_POW_SQ;
      S_POW_SQ: begin
        if (mul_done) state_next = (e[W-1:1] == '0) ? S_CHECK : S_POW_ACC;
      end
      S_CHECK: begin
        if (acc == W'(1) || acc == nm1) state_next = S_BASE;
        else if (s > 6'd1) state_next = S_SQR;
        else state_next = S_DONE;
      end
      S_SQR: begin
        if (mul_done) begin
          if (mul_prod == nm1) state_next = S_BASE;
          else if (r + 6'd1 >= s) state_next = S_DONE;
        end
      end
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    busy           = (state != S_IDLE);
    done           = (state == S_DONE);
    probably_prime = verdict;
    mul_go         = 1'b0;
    mul_x          = acc;
    mul_y          = acc;
    unique case (state)
      S_POW_ACC: begin
        mul_go = e[0] && !mul_run;
        mul_x  = acc;
        mul_y  = b;
      end
      S_POW_SQ: begin
        mul_go = !mul_run;
        mul_x  = b;
        mul_y  = b;
      end
      S_SQR:     mul_go = !mul_run;
      default:   mul_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mul_run <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_go) mul_run <= 1'b1;
      else if (mul_done) mul_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          n     <= candidate[W-1:0];
          nm1   <= candidate[W-1:0] - W'(1);
          d     <= candidate[W-1:0] - W'(1);
          s     <= '0;
          lt2   <= in_lt2;
          match <= in_match;
        end
      end
      S_TRIAL: begin
        bidx    <= '0;
        verdict <= !lt2 && match;
      end
      S_DECOMP: begin
        if (!(d[0] || s == 6'd63)) begin
          d <= {1'b0, d[W-1:1]};
          s <= s + 6'd1;
        end
      end
      S_BASE: begin
        acc <= W'(1);
        b   <= base_w;
        e   <= d;
        if (bidx == LAST_BASE) verdict <= 1'b1;
        else if (base_w >= n) bidx <= bidx + 3'd1;
      end
      S_POW_ACC: if (mul_done) acc <= mul_prod;
      S_POW_SQ: begin
        if (mul_done) begin
          b <= mul_prod;
          e <= {1'b0, e[W-1:1]};
        end
      end
      S_CHECK: begin
        r <= 6'd1;
        if (acc == W'(1) || acc == nm1) bidx <= bidx + 3'd1;
        else if (s <= 6'd1) verdict <= 1'b0;
      end
      S_SQR: begin
        if (mul_done) begin
          acc <= mul_prod;
          r   <= r + 6'd1;
          if (mul_prod == nm1) bidx <= bidx + 3'd1;
          else if (r + 6'd1 >= s) verdict <= 1'b0;
        end
      end
      default:   verdict <= verdict;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  assert property (@(posedge clk) disable iff (rst) start_ok |=> busy)
    else $error("transfer accepted but block not busy");

  assert property (@(posedge clk) disable iff (rst)
    mul_run |-> (state == S_POW_ACC || state == S_POW_SQ || state == S_SQR))
    else $error("multiplier running outside a product state");

  assert property (@(posedge clk) disable iff (rst) mul_done |-> mul_run)
    else $error("multiplier finished without a request");

endmodule

/* sim/tb_miller_rabin_primality_test_core.sv */
// testbench for the miller-rabin primality tester: directed and random candidates
`timescale 1ns / 100ps

module tb_miller_rabin_primality_test_core;
  import mrp_pkg::*;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        start;
  logic [63:0] candidate;
  logic        busy;
  logic        done;
  logic        probably_prime;

  logic        verdicts_due[$];
  int          failures;

  miller_rabin_primality_test_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .candidate(candidate),
    .busy(busy),
    .done(done),
    .probably_prime(probably_prime)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic logic [63:0] pow_mod(input logic [63:0] b, input logic [63:0] e,
                                          input logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic primality_of(input logic [63:0] n);
    logic [63:0] d;
    logic [63:0] x;
    logic [63:0] a;
    int          s;
    logic        witness;
    if (n < 2) return 1'b0;
    for (int i = 0; i < NUM_SMALL; i++) begin
      if (n == 64'(SMALL_PRIMES[i])) return 1'b1;
      if (n % 64'(SMALL_PRIMES[i]) == 0) return 1'b0;
    end
    d = n - 1;
    s = 0;
    while (!d[0] && s < 63) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < NUM_BASES; i++) begin
      a = 64'(base_of(3'(i)));
      if (a >= n) continue;
      x = pow_mod(a, d, n);
      if (x == 1 || x == n - 1) continue;
      witness = 1'b1;
      for (int r = 1; r < s; r++) begin
        x = mul_mod(x, x, n);
        if (x == n - 1) begin
          witness = 1'b0;
          break;
        end
      end
      if (witness) return 1'b0;
    end
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0b", $time, probably_prime);
        failures++;
      end else begin
        logic want;
        want = verdicts_due.pop_front();
        if (probably_prime !== want) begin
          $display("%0t: probably_prime mismatch, expected %0b, actual %0b",
                   $time, want, probably_prime);
          failures++;
        end
      end
    end
  end

  task automatic test_candidate(input logic [63:0] n);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    candidate <= n;
    do @(posedge clk); while (busy);
    verdicts_due.push_back(primality_of(n));
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      candidate <= {$urandom, $urandom};
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [63:0] list[$];
    list = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37, 64'd41, 64'd39, 64'd1369,
             64'd1763, 64'd561, 64'd25326001, 64'd3215031751, 64'd341550071728321,
             64'd2305843009213693951, 64'd18446744073709551557, ALL_ONES,
             64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'd999999000001};
    foreach (list[i]) test_candidate(list[i]);
  endtask

  task automatic test_pause_until_idle();
    wait_drained();
    test_candidate(64'd4294967291);
    test_candidate(64'd4294967297);
  endtask

  task automatic test_random();
    logic [63:0] n;
    for (int i = 0; i < 100; i++) begin
      case ($urandom_range(0, 2))
        0: n = {$urandom, $urandom};
        1: begin
          n = {$urandom, $urandom} | 64'd1;
          for (int k = 0; k < 400 && !primality_of(n); k++) n = n + 2;
        end
        default: n = 64'($urandom_range(0, 3000));
      endcase
      test_candidate(n);
    end
  endtask

  initial begin
    failures = 0;
    rst = 1'b1;
    start = 1'b0;
    candidate = 64'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_pause_until_idle();
    test_random();
    @(negedge clk);
    start <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("tb_miller_rabin_primality_test_core: PASS");
    end else begin
      $display("tb_miller_rabin_primality_test_core: FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_miller_rabin_primality_test_core: FAIL");
    $finish;
  end

endmodule
